FILE: design/pist_pkg.sv
// Shared types and constants for the point-in-solid containment unit.
// No dependencies; imported by point_in_solid_shape_test_unit and verif/tb.sv.

package pist_pkg;

  // Default coordinate width and fixed register geometry
  localparam int COORD_BITS_DEF = 20;
  localparam int SIZE_W         = 19;
  localparam int DATA_W         = 32;
  localparam int ADDR_W         = 5;
  localparam int REG_IDX_W      = 3;

  // Solid selected by the shape_kind register; code 7 means nothing
  typedef enum logic [2:0] {
    SHAPE_SPHERE    = 3'd0,
    SHAPE_ELLIPSOID = 3'd1,
    SHAPE_BOX       = 3'd2,
    SHAPE_CYLINDER  = 3'd3,
    SHAPE_OCTA      = 3'd4,
    SHAPE_TRUNC_OCT = 3'd5,
    SHAPE_CUBOCT    = 3'd6
  } shape_kind_t;

  // Cylinder axis; code 3 falls back to z
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } cyl_axis_t;

  // Register word index (byte address / 4)
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SHAPE_KIND = 3'd0,
    REG_CYL_AXIS   = 3'd1,
    REG_SIZE_A     = 3'd2,
    REG_SIZE_B     = 3'd3,
    REG_SIZE_C     = 3'd4
  } reg_idx_t;

endpackage

FILE: design/point_in_solid_shape_test_unit.sv
// Point-in-solid containment test: seven primitive solids, one point per clock.
// Depends on pist_pkg (shape, axis and register codes, field widths).

// Usage
//   Configure over the APB-style port (psel/penable/pwrite/paddr/pwdata) while
//   no point is in flight: shape_kind at 0x00, cylinder_axis at 0x04, size_a at
//   0x08, size_b at 0x0C, size_c at 0x10. Reads return the stored values;
//   pready is tied high, so every access completes without wait states.
//   Present a point on in_rel_x/y/z with start high; busy never rises, so a
//   new point word is taken at every clock edge that sees start.
//   Each point yields exactly one result word: out_inside_res is valid for
//   one cycle, flagged by out_strobe. Eight register stages sit between the
//   ports, the first loaded by the edge that takes the point; points are
//   accepted at a sustained rate of one point per cycle.
//   The latency is set by the ellipsoid path: magnitudes, two product levels
//   split into 19-bit slices, a rebuild, a split squaring, square assembly,
//   the three-term sum and the final compare each take one register stage.
//   The receiver cannot stall the unit, so no backpressure exists; results
//   leave in order, one per accepted point.
//   rst_n (synchronous, active low) drops all in-flight points and restores
//   the registers: sphere, z axis, all sizes zero.

module point_in_solid_shape_test_unit
  import pist_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // point channel
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_rel_x,
  input  logic signed [COORD_BITS-1:0] in_rel_y,
  input  logic signed [COORD_BITS-1:0] in_rel_z,
  // result channel
  output logic                         out_strobe,
  output logic                         out_inside_res,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [DATA_W-1:0]            pwdata,
  output logic [DATA_W-1:0]            prdata,
  output logic                         pready
);

  localparam int CW      = COORD_BITS;
  localparam int MAXW    = (CW > SIZE_W) ? CW : SIZE_W;
  localparam int CMP_W   = MAXW + 2;                 // linear sums and compares
  localparam int SQ_W    = 2 * CW;                   // coordinate squares
  localparam int QCMP_W  = 2 * MAXW + 2;             // sums of squares
  localparam int AA_W    = 2 * SIZE_W;               // size products
  localparam int U_W     = 3 * SIZE_W;               // x*b*c and friends
  localparam int SPLIT   = (U_W + 1) / 2;            // low slice for squaring
  localparam int HI_W    = U_W - SPLIT;
  localparam int HH_W    = 2 * HI_W;
  localparam int HL_W    = HI_W + SPLIT;
  localparam int LL_W    = 2 * SPLIT;
  localparam int SQE_W   = 2 * U_W;                  // squared 57-bit terms
  localparam int LHS_W   = SQE_W + 2;
  localparam int LANES   = 4;                        // u, v, w, r
  localparam int NSTG    = 7;

  // Two's complement magnitude; the most negative code maps to 2^(CW-1)
  function automatic logic [CW-1:0] mag_f(input logic [CW-1:0] v);
    logic [CW-1:0] neg;
    neg = ~v + CW'(1);
    return v[CW-1] ? neg : v;
  endfunction

  // ---------------------------------------------------------------- registers
  shape_kind_t       shape_kind_r;
  cyl_axis_t         cyl_axis_r;
  logic [SIZE_W-1:0] size_a_r, size_b_r, size_c_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_kind_r <= SHAPE_SPHERE;
      cyl_axis_r   <= AXIS_Z;
      size_a_r     <= '0;
      size_b_r     <= '0;
      size_c_r     <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SHAPE_KIND: shape_kind_r <= shape_kind_t'(pwdata[2:0]);
        REG_CYL_AXIS:   cyl_axis_r   <= cyl_axis_t'(pwdata[1:0]);
        REG_SIZE_A:     size_a_r     <= pwdata[SIZE_W-1:0];
        REG_SIZE_B:     size_b_r     <= pwdata[SIZE_W-1:0];
        REG_SIZE_C:     size_c_r     <= pwdata[SIZE_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SHAPE_KIND: prdata = DATA_W'(shape_kind_r);
      REG_CYL_AXIS:   prdata = DATA_W'(cyl_axis_r);
      REG_SIZE_A:     prdata = DATA_W'(size_a_r);
      REG_SIZE_B:     prdata = DATA_W'(size_b_r);
      REG_SIZE_C:     prdata = DATA_W'(size_c_r);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- valid pipe
  logic [NSTG-1:0] vld_r, vld_nxt;
  logic            out_strobe_r;

  assign vld_nxt = {vld_r[NSTG-2:0], start && !busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= vld_nxt;
      out_strobe_r <= vld_r[NSTG-1];
    end
  end

  assign out_strobe = out_strobe_r;

  // ---------------------------------------------------------------- stage 1
  // Capture coordinate magnitudes.
  logic [CW-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [CW-1:0] s1_x_nxt, s1_y_nxt, s1_z_nxt;

  always_comb begin
    s1_x_nxt = mag_f(in_rel_x);
    s1_y_nxt = mag_f(in_rel_y);
    s1_z_nxt = mag_f(in_rel_z);
  end

  // ---------------------------------------------------------------- stage 2
  // Linear solids, axis bound, squares, and the first ellipsoid products.
  logic              s2_flat_nxt, s2_axis_ok_nxt, s2_ok_e_nxt;
  logic              s2_flat_r, s2_axis_ok_r, s2_ok_e_r;
  logic [SQ_W-1:0]   s2_xx_nxt, s2_yy_nxt, s2_zz_nxt;
  logic [SQ_W-1:0]   s2_xx_r, s2_yy_r, s2_zz_r;
  logic [AA_W-1:0]   s2_aa_nxt, s2_aa_r;
  logic [AA_W-1:0]   s2_eop_nxt [LANES];
  logic [AA_W-1:0]   s2_eop_r   [LANES];
  logic [SIZE_W-1:0] xe, ye, ze;
  logic [CMP_W-1:0]  sum_xyz, sum_xy, sum_yz, sum_xz;
  logic              bx_a, by_b, bz_c, bx_b, by_bb, bz_b, oct_ok;

  always_comb begin
    sum_xyz = CMP_W'(s1_x_r) + CMP_W'(s1_y_r) + CMP_W'(s1_z_r);
    sum_xy  = CMP_W'(s1_x_r) + CMP_W'(s1_y_r);
    sum_yz  = CMP_W'(s1_y_r) + CMP_W'(s1_z_r);
    sum_xz  = CMP_W'(s1_x_r) + CMP_W'(s1_z_r);
    bx_a    = CMP_W'(s1_x_r) <= CMP_W'(size_a_r);
    by_b    = CMP_W'(s1_y_r) <= CMP_W'(size_b_r);
    bz_c    = CMP_W'(s1_z_r) <= CMP_W'(size_c_r);
    bx_b    = CMP_W'(s1_x_r) <= CMP_W'(size_b_r);
    by_bb   = by_b;
    bz_b    = CMP_W'(s1_z_r) <= CMP_W'(size_b_r);
    oct_ok  = sum_xyz <= CMP_W'(size_a_r);

    case (shape_kind_r)
      SHAPE_BOX:       s2_flat_nxt = bx_a && by_b && bz_c;
      SHAPE_OCTA:      s2_flat_nxt = oct_ok;
      SHAPE_TRUNC_OCT: s2_flat_nxt = oct_ok && bx_b && by_bb && bz_b;
      SHAPE_CUBOCT:    s2_flat_nxt = (sum_xy <= CMP_W'(size_a_r))
                                     && (sum_yz <= CMP_W'(size_a_r))
                                     && (sum_xz <= CMP_W'(size_a_r));
      default:         s2_flat_nxt = 1'b0;
    endcase

    case (cyl_axis_r)
      AXIS_X:  s2_axis_ok_nxt = bx_b;
      AXIS_Y:  s2_axis_ok_nxt = by_bb;
      default: s2_axis_ok_nxt = bz_b;
    endcase

    s2_xx_nxt = s1_x_r * s1_x_r;
    s2_yy_nxt = s1_y_r * s1_y_r;
    s2_zz_nxt = s1_z_r * s1_z_r;
    s2_aa_nxt = size_a_r * size_a_r;

    // Beyond a semi-axis is outside, so the slices below stay in range
    s2_ok_e_nxt = (size_a_r != '0) && (size_b_r != '0) && (size_c_r != '0)
                  && bx_a && by_b && bz_c;
    xe = SIZE_W'(s1_x_r);
    ye = SIZE_W'(s1_y_r);
    ze = SIZE_W'(s1_z_r);
    s2_eop_nxt[0] = xe * size_b_r;        // x*b
    s2_eop_nxt[1] = ye * size_a_r;        // y*a
    s2_eop_nxt[2] = ze * size_a_r;        // z*a
    s2_eop_nxt[3] = size_a_r * size_b_r;  // a*b
  end

  // ---------------------------------------------------------------- stage 3
  // Quadratic solids; second ellipsoid factor in two 19-bit slices.
  logic              s3_simple_nxt, s3_simple_r, s3_ok_e_r;
  logic [AA_W-1:0]   s3_lo_nxt [LANES];
  logic [AA_W-1:0]   s3_hi_nxt [LANES];
  logic [AA_W-1:0]   s3_lo_r   [LANES];
  logic [AA_W-1:0]   s3_hi_r   [LANES];
  logic [SIZE_W-1:0] emul [LANES];
  logic [QCMP_W-1:0] sph_sum, cyl_sum;

  always_comb begin
    sph_sum = QCMP_W'(s2_xx_r) + QCMP_W'(s2_yy_r) + QCMP_W'(s2_zz_r);
    case (cyl_axis_r)
      AXIS_X:  cyl_sum = QCMP_W'(s2_yy_r) + QCMP_W'(s2_zz_r);
      AXIS_Y:  cyl_sum = QCMP_W'(s2_xx_r) + QCMP_W'(s2_zz_r);
      default: cyl_sum = QCMP_W'(s2_xx_r) + QCMP_W'(s2_yy_r);
    endcase

    case (shape_kind_r)
      SHAPE_SPHERE:    s3_simple_nxt = sph_sum <= QCMP_W'(s2_aa_r);
      SHAPE_CYLINDER:  s3_simple_nxt = (cyl_sum <= QCMP_W'(s2_aa_r)) && s2_axis_ok_r;
      SHAPE_ELLIPSOID: s3_simple_nxt = 1'b0;
      default:         s3_simple_nxt = s2_flat_r;
    endcase

    emul[0] = size_c_r;   // u = x*b*c
    emul[1] = size_c_r;   // v = y*a*c
    emul[2] = size_b_r;   // w = z*a*b
    emul[3] = size_c_r;   // r = a*b*c
    for (int i = 0; i < LANES; i++) begin
      s3_lo_nxt[i] = s2_eop_r[i][SIZE_W-1:0] * emul[i];
      s3_hi_nxt[i] = s2_eop_r[i][AA_W-1:SIZE_W] * emul[i];
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Rebuild the 57-bit terms from the slices.
  logic           s4_simple_r, s4_ok_e_r;
  logic [U_W-1:0] s4_u_nxt [LANES];
  logic [U_W-1:0] s4_u_r   [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      s4_u_nxt[i] = {s3_hi_r[i], {SIZE_W{1'b0}}} + U_W'(s3_lo_r[i]);
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Square each term as high and low halves.
  logic            s5_simple_r, s5_ok_e_r;
  logic [HH_W-1:0] s5_hh_nxt [LANES];
  logic [HL_W-1:0] s5_hl_nxt [LANES];
  logic [LL_W-1:0] s5_ll_nxt [LANES];
  logic [HH_W-1:0] s5_hh_r   [LANES];
  logic [HL_W-1:0] s5_hl_r   [LANES];
  logic [LL_W-1:0] s5_ll_r   [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      s5_hh_nxt[i] = s4_u_r[i][U_W-1:SPLIT] * s4_u_r[i][U_W-1:SPLIT];
      s5_hl_nxt[i] = s4_u_r[i][U_W-1:SPLIT] * s4_u_r[i][SPLIT-1:0];
      s5_ll_nxt[i] = s4_u_r[i][SPLIT-1:0] * s4_u_r[i][SPLIT-1:0];
    end
  end

  // ---------------------------------------------------------------- stage 6
  // Assemble the full squares; the cross term counts twice.
  logic             s6_simple_r, s6_ok_e_r;
  logic [SQE_W-1:0] s6_sq_nxt [LANES];
  logic [SQE_W-1:0] s6_sq_r   [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      s6_sq_nxt[i] = (SQE_W'(s5_hh_r[i]) << (2 * SPLIT))
                   + (SQE_W'(s5_hl_r[i]) << (SPLIT + 1))
                   + SQE_W'(s5_ll_r[i]);
    end
  end

  // ---------------------------------------------------------------- stage 7
  // Sum the three axis terms.
  logic             s7_simple_r, s7_ok_e_r;
  logic [LHS_W-1:0] s7_lhs_nxt, s7_lhs_r;
  logic [SQE_W-1:0] s7_r2_r;

  assign s7_lhs_nxt = LHS_W'(s6_sq_r[0]) + LHS_W'(s6_sq_r[1]) + LHS_W'(s6_sq_r[2]);

  // ---------------------------------------------------------------- output
  logic out_inside_nxt, out_inside_r;

  always_comb begin
    if (shape_kind_r == SHAPE_ELLIPSOID) begin
      out_inside_nxt = s7_ok_e_r && (s7_lhs_r <= LHS_W'(s7_r2_r));
    end else begin
      out_inside_nxt = s7_simple_r;
    end
  end

  assign out_inside_res = out_inside_r;

  // Payload advances every cycle; the valid pipe says which words are live.
  always_ff @(posedge clk) begin
    s1_x_r       <= s1_x_nxt;
    s1_y_r       <= s1_y_nxt;
    s1_z_r       <= s1_z_nxt;

    s2_flat_r    <= s2_flat_nxt;
    s2_axis_ok_r <= s2_axis_ok_nxt;
    s2_ok_e_r    <= s2_ok_e_nxt;
    s2_xx_r      <= s2_xx_nxt;
    s2_yy_r      <= s2_yy_nxt;
    s2_zz_r      <= s2_zz_nxt;
    s2_aa_r      <= s2_aa_nxt;
    s2_eop_r     <= s2_eop_nxt;

    s3_simple_r  <= s3_simple_nxt;
    s3_ok_e_r    <= s2_ok_e_r;
    s3_lo_r      <= s3_lo_nxt;
    s3_hi_r      <= s3_hi_nxt;

    s4_simple_r  <= s3_simple_r;
    s4_ok_e_r    <= s3_ok_e_r;
    s4_u_r       <= s4_u_nxt;

    s5_simple_r  <= s4_simple_r;
    s5_ok_e_r    <= s4_ok_e_r;
    s5_hh_r      <= s5_hh_nxt;
    s5_hl_r      <= s5_hl_nxt;
    s5_ll_r      <= s5_ll_nxt;

    s6_simple_r  <= s5_simple_r;
    s6_ok_e_r    <= s5_ok_e_r;
    s6_sq_r      <= s6_sq_nxt;

    s7_simple_r  <= s6_simple_r;
    s7_ok_e_r    <= s6_ok_e_r;
    s7_lhs_r     <= s7_lhs_nxt;
    s7_r2_r      <= s6_sq_r[3];

    out_inside_r <= out_inside_nxt;
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for point_in_solid_shape_test_unit: points in, one inside flag out.
// Depends on pist_pkg for widths, shape, axis and register codes, and on the unit itself.

import pist_pkg::*;

localparam int CW = COORD_BITS_DEF;

// Mirror of the solid registers plus the queue of flags still owed by the unit.
class containment_board;
  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flag;
  } point_word_t;

  logic [2:0]        kind;
  logic [1:0]        axis;
  logic [SIZE_W-1:0] size_a;
  logic [SIZE_W-1:0] size_b;
  logic [SIZE_W-1:0] size_c;
  point_word_t       flags_due[$];
  int                errors;

  function new();
    kind   = SHAPE_SPHERE;
    axis   = AXIS_Z;
    size_a = '0;
    size_b = '0;
    size_c = '0;
    errors = 0;
  endfunction

  // Only the low bits of each register are kept; other indexes are dropped.
  function void set_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    case (idx)
      REG_SHAPE_KIND: kind   = value[2:0];
      REG_CYL_AXIS:   axis   = value[1:0];
      REG_SIZE_A:     size_a = value[SIZE_W-1:0];
      REG_SIZE_B:     size_b = value[SIZE_W-1:0];
      REG_SIZE_C:     size_c = value[SIZE_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [DATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_SHAPE_KIND: return DATA_W'(kind);
      REG_CYL_AXIS:   return DATA_W'(axis);
      REG_SIZE_A:     return DATA_W'(size_a);
      REG_SIZE_B:     return DATA_W'(size_b);
      default:        return DATA_W'(size_c);
    endcase
  endfunction

  // Two's complement magnitude; the most negative code maps to 2^(CW-1).
  function logic [CW-1:0] magnitude(logic [CW-1:0] raw);
    return raw[CW-1] ? (~raw + 1'b1) : raw;
  endfunction

  function logic inside_solid(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz);
    logic [63:0]  x, y, z, a, b, c, r2, along;
    logic [127:0] u, v, w, abc;
    x = 64'(magnitude(px));
    y = 64'(magnitude(py));
    z = 64'(magnitude(pz));
    a = 64'(size_a);
    b = 64'(size_b);
    c = 64'(size_c);
    case (kind)
      SHAPE_SPHERE: return x * x + y * y + z * z <= a * a;
      SHAPE_ELLIPSOID: begin
        // Zero semi-axis or any magnitude past its semi-axis: outside.
        if (a == 0 || b == 0 || c == 0 || x > a || y > b || z > c) return 1'b0;
        u   = x * b * c;
        v   = y * a * c;
        w   = z * a * b;
        abc = a * b * c;
        return u * u + v * v + w * w <= abc * abc;
      end
      SHAPE_BOX: return x <= a && y <= b && z <= c;
      SHAPE_CYLINDER: begin
        case (axis)
          AXIS_X: begin
            r2 = y * y + z * z;
            along = x;
          end
          AXIS_Y: begin
            r2 = x * x + z * z;
            along = y;
          end
          default: begin
            // z axis, and the unused axis code as well
            r2 = x * x + y * y;
            along = z;
          end
        endcase
        return r2 <= a * a && along <= b;
      end
      SHAPE_OCTA:      return x + y + z <= a;
      SHAPE_TRUNC_OCT: return x + y + z <= a && x <= b && y <= b && z <= b;
      SHAPE_CUBOCT:    return x + y <= a && y + z <= a && x + z <= a;
      default:         return 1'b0;
    endcase
  endfunction

  function void note_point(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz);
    point_word_t w;
    w.x = px;
    w.y = py;
    w.z = pz;
    w.flag = inside_solid(px, py, pz);
    flags_due = {flags_due, w};
  endfunction

  function void check_flag(logic got);
    point_word_t w;
    if (flags_due.size() == 0) begin
      errors++;
      $display("%0t: result word inside=%0b arrived, expected none", $time, got);
      return;
    end
    w = flags_due.pop_front();
    if (w.flag !== got) begin
      errors++;
      $display("%0t: point (%0d,%0d,%0d) shape %0d: expected inside=%0b, actual %0b",
               $time, w.x, w.y, w.z, kind, w.flag, got);
    end
  endfunction

  function int pending();
    return flags_due.size();
  endfunction
endclass

module tb;
  // Codes the package leaves out: reserved shape, reserved axis, first hole in the map
  localparam logic [2:0]           SHAPE_UNUSED = 3'd7;
  localparam logic [1:0]           AXIS_UNUSED  = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED   = REG_IDX_W'(REG_SIZE_C + 1);
  localparam logic [REG_IDX_W-1:0] REG_TOP      = '1;

  localparam logic [DATA_W-1:0]    SIZE_MAX = (1 << SIZE_W) - 1;
  localparam logic signed [CW-1:0] C_MAX    = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN    = {1'b1, {(CW-1){1'b0}}};

  // Fixed pipeline depth is 8; leave some margin at the end of the run.
  localparam int TAIL_CYCLES = 16;
  localparam int CYCLE_LIMIT = 200000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [CW-1:0]     in_rel_x = '0;
  logic signed [CW-1:0]     in_rel_y = '0;
  logic signed [CW-1:0]     in_rel_z = '0;
  logic                     out_strobe;
  logic                     out_inside_res;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [DATA_W-1:0]        pwdata = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  containment_board board = new();
  int unsigned      cycle_count = 0;

  always #4 clk = ~clk;

  point_in_solid_shape_test_unit #(.COORD_BITS(CW)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_rel_x       (in_rel_x),
    .in_rel_y       (in_rel_y),
    .in_rel_z       (in_rel_z),
    .out_strobe     (out_strobe),
    .out_inside_res (out_inside_res),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Watchdog: a missing result word or a stuck handshake lands here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: the unit cannot be stalled, so take every strobed word.
  // Sampling right after the edge sees the values of the cycle that just ended.
  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_flag(out_inside_res);
  end

  // Present one point and hold it until an edge sees start with busy low.
  // Leave start high afterwards so back-to-back points need no extra drive.
  task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                            input logic signed [CW-1:0] z);
    start    <= 1'b1;
    in_rel_x <= x;
    in_rel_y <= y;
    in_rel_z <= z;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_point(x, y, z);
  endtask

  // Drop start and idle for the pause that n asks for (n >= 1).
  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop start and wait until every point in flight has reported back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Setup phase, access phase, then an idle gap so transfers never abut.
  task automatic apb_transfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register, mirror it, and read it back where the index is mapped.
  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] got;
    apb_transfer(1'b1, idx, value);
    board.set_reg(idx, value);
    if (idx <= REG_SIZE_C) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (pready !== 1'b1);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== board.reg_value(idx)) begin
        board.errors++;
        $display("%0t: register %0d read back: expected %0h, actual %0h",
                 $time, idx, board.reg_value(idx), got);
      end
      @(posedge clk);
    end
  endtask

  // Registers change only with nothing in flight.
  task automatic configure(input logic [DATA_W-1:0] kind, input logic [DATA_W-1:0] axis,
                           input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                           input logic [DATA_W-1:0] c);
    drain();
    cfg_write(REG_SHAPE_KIND, kind);
    cfg_write(REG_CYL_AXIS, axis);
    cfg_write(REG_SIZE_A, a);
    cfg_write(REG_SIZE_B, b);
    cfg_write(REG_SIZE_C, c);
  endtask

  // Sizes lean on the corners (zero, one, full scale) with plenty of small values.
  function automatic logic [DATA_W-1:0] rand_size();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return SIZE_MAX;
      3, 4, 5: return $urandom_range(0, 2000);
      default: return $urandom_range(0, SIZE_MAX);
    endcase
  endfunction

  // Fill the bits above a register's width with junk; the unit must ignore them.
  function automatic logic [DATA_W-1:0] junk_above(input logic [DATA_W-1:0] v, input int w);
    return ($urandom << w) | v;
  endfunction

  // Coordinates mostly scaled to the solid so both answers show up often,
  // with some raw full-range words and some range extremes mixed in.
  function automatic logic signed [CW-1:0] rand_coord(input int unsigned base);
    int unsigned          mag;
    logic signed [CW-1:0] v;
    case ($urandom_range(0, 7))
      0: return CW'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0:       return C_MIN;
          1:       return C_MAX;
          2:       return '0;
          3:       return CW'(1);
          default: return '1;
        endcase
      end
      default: begin
        mag = $urandom_range(0, base * $urandom_range(1, 6) / 4 + 2);
        if (mag > (1 << (CW - 1))) mag = 1 << (CW - 1);
        v = CW'(mag);
        if ($urandom_range(0, 1)) v = -v;
        else if (mag > C_MAX) v = C_MAX;
        return v;
      end
    endcase
  endfunction

  task automatic send_random_point();
    int unsigned bx, by, bz;
    bx = board.size_a;
    by = $urandom_range(0, 1) ? board.size_a : board.size_b;
    bz = $urandom_range(0, 1) ? board.size_a : board.size_c;
    send_point(rand_coord(bx), rand_coord(by), rand_coord(bz));
  endtask

  task automatic directed_points();
    // Reset state is a sphere of radius zero: only the centre is inside.
    send_point(0, 0, 0);
    send_point(1, 0, 0);
    // Full-scale sphere, radius written with junk in the upper bits
    configure(junk_above(SHAPE_SPHERE, 3), AXIS_Z, '1, 0, 0);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(C_MAX, 0, 0);
    // Ellipsoid with a zero semi-axis reports outside even at the centre
    configure(SHAPE_ELLIPSOID, AXIS_Z, 5, 0, 7);
    send_point(0, 0, 0);
    // Full-scale ellipsoid exercises the widest products
    configure(SHAPE_ELLIPSOID, AXIS_Z, SIZE_MAX, SIZE_MAX, SIZE_MAX);
    send_point(C_MAX, 0, 0);
    send_point(C_MIN, 0, 0);
    send_point(300000, -300000, 300000);
    configure(SHAPE_BOX, AXIS_Z, 100, 200, 300);
    send_point(100, -200, 300);
    send_point(-101, 0, 0);
    // Cylinder on each axis, radius 1000, half-height 50; points on or just past the boundary
    configure(SHAPE_CYLINDER, AXIS_X, 1000, 50, 0);
    send_point(50, 600, -800);
    configure(SHAPE_CYLINDER, AXIS_Y, 1000, 50, 0);
    send_point(600, -51, 800);
    configure(SHAPE_CYLINDER, AXIS_Z, 1000, 50, 0);
    send_point(-600, 800, 50);
    // Reserved axis code behaves as z
    configure(SHAPE_CYLINDER, AXIS_UNUSED, 1000, 50, 0);
    send_point(600, 800, 51);
    configure(SHAPE_OCTA, AXIS_Z, 1000, 0, 0);
    send_point(333, -333, 334);
    send_point(333, -333, -335);
    configure(SHAPE_TRUNC_OCT, AXIS_Z, 1000, 400, 0);
    send_point(400, -300, 300);
    send_point(-401, 0, 0);
    configure(SHAPE_CUBOCT, AXIS_Z, 1000, 0, 0);
    send_point(500, -500, 500);
    send_point(500, 501, 0);
    // Reserved shape code is never inside; a write to an unmapped index changes nothing
    configure(SHAPE_UNUSED, AXIS_Z, 1000, 1000, 1000);
    cfg_write(REG_UNUSED, '1);
    send_point(0, 0, 0);
  endtask

  initial begin
    int   remaining;
    int   burst;
    logic gaps_on;
    logic [DATA_W-1:0] kind;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_points();

    // Random phases: new solid each phase, then bursts of points.
    // Every third phase runs with no pauses between bursts, only the occasional drain.
    for (int phase = 0; phase < 14; phase++) begin
      kind = ($urandom_range(0, 15) == 0) ? SHAPE_UNUSED : $urandom_range(0, 6);
      configure(junk_above(kind, 3), junk_above($urandom_range(0, 3), 2),
                junk_above(rand_size(), SIZE_W), junk_above(rand_size(), SIZE_W),
                junk_above(rand_size(), SIZE_W));
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(REG_IDX_W'($urandom_range(REG_UNUSED, REG_TOP)), $urandom);
      end
      remaining = $urandom_range(28, 44);
      gaps_on   = (phase % 3) != 0;
      while (remaining > 0) begin
        burst = $urandom_range(1, 12);
        while (burst > 0 && remaining > 0) begin
          send_random_point();
          burst--;
          remaining--;
        end
        // Now and then hold off until the pipeline is empty
        if ($urandom_range(0, 19) == 0) drain();
        else if (gaps_on) pause($urandom_range(1, 7));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

FILE: sim.f
design/pist_pkg.sv
design/point_in_solid_shape_test_unit.sv
verif/tb.sv
